[src/tpi_pkg.sv]
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types and constants for the track point interpolator.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int unsigned TDATA_W   = 160;
    localparam int unsigned MAG_W     = 33;
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned ACC_W     = MAG_W + NUM_W;
    localparam int unsigned WIDE_W    = MAG_W + 1;
    localparam int unsigned MUL_STEPS = NUM_W;
    localparam int unsigned DIV_STEPS = ACC_W;
    localparam int unsigned NUM_LANES = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_EXACT   = 3'd0,
        ST_INTERP  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BEFORE  = 3'd3,
        ST_AFTER   = 3'd4,
        ST_LOADED  = 3'd5,
        ST_FULL    = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } lane_state_t;

    typedef struct packed {
        logic        [31:0] stamp;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic signed [24:0] alt;
        logic        [19:0] speed;
        logic        [15:0] heading;
    } point_t;

    function automatic logic [WIDE_W-1:0] apply_frac(logic [WIDE_W-1:0] base, logic neg,
                                                     logic [MAG_W-1:0] frac);
        logic [WIDE_W-1:0] f;
        f = {1'b0, frac};
        return neg ? base - f : base + f;
    endfunction

    function automatic logic [TDATA_W-1:0] pack_point(point_t p);
        return {4'd0, p.heading, p.speed, p.alt, p.lon, p.lat, p.stamp};
    endfunction

endpackage

[src/track_point_interpolator.sv]
// ----------------------------------------------------------------------------
// track_point_interpolator
// Track point table with append, clear and time-interpolated lookup.
// ----------------------------------------------------------------------------
// Append, clear and empty-table queries finish in the cycle they are taken.
// Any other query reads the last point, then scans the table from the start,
// one entry per cycle through the single memory read port, until the first
// point not earlier than the query time. A query before the first point or
// after the last one stops the scan at entry 0. An interpolated answer then
// passes through the blend lanes (32 multiply steps, 65 divide steps, one to
// finish), all quantities in parallel. One transaction is worked on at a time.
module track_point_interpolator #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // stamp_seconds, lat_in, lon_in, alt_in, speed_in, heading_in
    input  logic [1:0]   s_tuser,  // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,  // stamp_out, lat_out, lon_out, alt_out, speed_out, heading_out
    output logic [3:0]   m_tuser   // status, measured
);

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned WW = tpi_pkg::WIDE_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LAST  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_BLEND = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [31:0]         ts_reg, ts_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       didx_reg, didx_next;
    logic                after_reg, after_next;
    tpi_pkg::point_t     prev_reg, prev_next;
    logic [tpi_pkg::NUM_LANES-1:0] neg_reg, neg_next;
    logic [159:0]        pend_data_reg, pend_data_next;
    logic [3:0]          pend_user_reg, pend_user_next;
    logic                m_valid_reg, m_valid_next;
    logic [159:0]        m_data_reg, m_data_next;
    logic [3:0]          m_user_reg, m_user_next;

    tpi_pkg::point_t     in_pt, rd_pt;
    tpi_pkg::cmd_t       cmd;
    logic                s_fire, slot_free, wr_en, lane_start, is_last;
    logic [AW-1:0]       rd_addr, last_addr;
    logic [31:0]         num, den;
    logic [WW-1:0]       diff [tpi_pkg::NUM_LANES];
    logic [tpi_pkg::MAG_W-1:0] mag [tpi_pkg::NUM_LANES];
    logic [tpi_pkg::MAG_W-1:0] frac [tpi_pkg::NUM_LANES];
    logic [tpi_pkg::NUM_LANES-1:0] lane_done;
    logic [WW-1:0]       hd;
    tpi_pkg::point_t     blend_pt;

    assign in_pt.stamp   = s_tdata[31:0];
    assign in_pt.lat     = s_tdata[62:32];
    assign in_pt.lon     = s_tdata[94:63];
    assign in_pt.alt     = s_tdata[119:95];
    assign in_pt.speed   = s_tdata[139:120];
    assign in_pt.heading = s_tdata[155:140];
    assign cmd           = tpi_pkg::cmd_t'(s_tuser);

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign s_fire    = s_tvalid && s_tready;
    assign wr_en     = s_fire && (cmd == tpi_pkg::CMD_APPEND) && (cnt_reg < CW'(MAX_POINTS));
    assign last_addr = AW'(cnt_reg - CW'(1));
    assign is_last   = didx_reg == last_addr;

    always_comb begin
        case (state_reg)
            S_SCAN:  rd_addr = idx_reg;
            S_LAST:  rd_addr = '0;
            default: rd_addr = last_addr;
        endcase
    end

    tpi_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(cnt_reg)),
        .wr_data (in_pt),
        .rd_addr (rd_addr),
        .rd_data (rd_pt)
    );

    // post is rd_pt, pre is prev_reg at the scan hit
    assign num = ts_reg - prev_reg.stamp;
    assign den = rd_pt.stamp - prev_reg.stamp;

    always_comb begin
        diff[0] = WW'(rd_pt.lat) - WW'(prev_reg.lat);
        diff[1] = WW'(rd_pt.lon) - WW'(prev_reg.lon);
        diff[2] = WW'(rd_pt.alt) - WW'(prev_reg.alt);
        diff[3] = WW'(rd_pt.speed) - WW'(prev_reg.speed);
        hd      = WW'(rd_pt.heading) - WW'(prev_reg.heading);
        if ($signed(hd) > $signed(WW'(32768))) begin
            hd = hd - WW'(65536);
        end else if ($signed(hd) < -$signed(WW'(32768))) begin
            hd = hd + WW'(65536);
        end
        diff[4] = hd;
        for (int i = 0; i < tpi_pkg::NUM_LANES; i++) begin
            mag[i] = diff[i][WW-1] ? tpi_pkg::MAG_W'(-diff[i])
                                   : diff[i][tpi_pkg::MAG_W-1:0];
        end
    end

    for (genvar g = 0; g < tpi_pkg::NUM_LANES; g++) begin : g_lane
        tpi_blend_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .mag     (mag[g]),
            .num     (num),
            .den     (den),
            .done    (lane_done[g]),
            .frac    (frac[g])
        );
    end

    always_comb begin
        blend_pt.stamp   = ts_reg;
        blend_pt.lat     = 31'(tpi_pkg::apply_frac(WW'(prev_reg.lat), neg_reg[0], frac[0]));
        blend_pt.lon     = 32'(tpi_pkg::apply_frac(WW'(prev_reg.lon), neg_reg[1], frac[1]));
        blend_pt.alt     = 25'(tpi_pkg::apply_frac(WW'(prev_reg.alt), neg_reg[2], frac[2]));
        blend_pt.speed   = 20'(tpi_pkg::apply_frac(WW'(prev_reg.speed), neg_reg[3], frac[3]));
        blend_pt.heading = 16'(tpi_pkg::apply_frac(WW'(prev_reg.heading), neg_reg[4],
                                                   frac[4]));
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ts_next        = ts_reg;
        idx_next       = idx_reg;
        didx_next      = idx_reg;
        after_next     = after_reg;
        prev_next      = prev_reg;
        neg_next       = neg_reg;
        pend_data_next = pend_data_reg;
        pend_user_next = pend_user_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        lane_start     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    ts_next     = in_pt.stamp;
                    m_data_next = {128'd0, in_pt.stamp};
                    case (cmd)
                        tpi_pkg::CMD_APPEND: begin
                            m_valid_next = 1'b1;
                            if (wr_en) begin
                                cnt_next    = cnt_reg + CW'(1);
                                m_user_next = {1'b0, tpi_pkg::ST_LOADED};
                            end else begin
                                m_user_next = {1'b0, tpi_pkg::ST_FULL};
                            end
                        end
                        tpi_pkg::CMD_CLEAR: begin
                            cnt_next     = '0;
                            m_valid_next = 1'b1;
                            m_user_next  = {1'b0, tpi_pkg::ST_CLEARED};
                        end
                        tpi_pkg::CMD_QUERY: begin
                            if (cnt_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_user_next  = {1'b0, tpi_pkg::ST_EMPTY};
                            end else begin
                                state_next = S_LAST;
                            end
                        end
                        default: begin
                            m_data_next = m_data_reg;
                        end
                    endcase
                end
            end
            S_LAST: begin
                // before-start takes priority over after-end, so entry 0 is always read
                pend_data_next = {128'd0, ts_reg};
                pend_user_next = {1'b0, tpi_pkg::ST_AFTER};
                after_next     = ts_reg > rd_pt.stamp;
                idx_next       = AW'(1);
                didx_next      = '0;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                idx_next  = idx_reg + AW'(1);
                prev_next = rd_pt;
                if (didx_reg == '0 && ts_reg < rd_pt.stamp) begin
                    pend_data_next = {128'd0, ts_reg};
                    pend_user_next = {1'b0, tpi_pkg::ST_BEFORE};
                    state_next     = S_OUT;
                end else if (after_reg) begin
                    state_next = S_OUT;
                end else if (rd_pt.stamp == ts_reg) begin
                    pend_data_next = tpi_pkg::pack_point(rd_pt);
                    pend_user_next = {1'b1, tpi_pkg::ST_EXACT};
                    state_next     = S_OUT;
                end else if (rd_pt.stamp > ts_reg || is_last) begin
                    prev_next  = prev_reg;
                    lane_start = 1'b1;
                    for (int i = 0; i < tpi_pkg::NUM_LANES; i++) begin
                        neg_next[i] = diff[i][WW-1];
                    end
                    state_next = S_BLEND;
                end
            end
            S_BLEND: begin
                if (lane_done[0]) begin
                    pend_data_next = tpi_pkg::pack_point(blend_pt);
                    pend_user_next = {1'b0, tpi_pkg::ST_INTERP};
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_data_reg;
                    m_user_next  = pend_user_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        ts_reg        <= ts_next;
        idx_reg       <= idx_next;
        didx_reg      <= didx_next;
        after_reg     <= after_next;
        prev_reg      <= prev_next;
        neg_reg       <= neg_next;
        pend_data_reg <= pend_data_next;
        pend_user_reg <= pend_user_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> didx_reg < AW'(cnt_reg) || cnt_reg == CW'(MAX_POINTS))
        else $error("scan beyond last stored point");

    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] |-> &lane_done && state_reg == S_BLEND)
        else $error("blend lanes out of step");

    a_start_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_start |=> state_reg == S_BLEND)
        else $error("blend started outside a scan hit");

endmodule

[src/tpi_point_mem.sv]
// ----------------------------------------------------------------------------
// tpi_point_mem
// Point table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpi_point_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tpi_pkg::point_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output tpi_pkg::point_t rd_data
);

    tpi_pkg::point_t mem [DEPTH];
    tpi_pkg::point_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/tpi_blend_lane.sv]
// ----------------------------------------------------------------------------
// tpi_blend_lane
// Computes floor(mag * num / den): shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
module tpi_blend_lane (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tpi_pkg::MAG_W-1:0] mag,
    input  logic [tpi_pkg::NUM_W-1:0] num,
    input  logic [tpi_pkg::NUM_W-1:0] den,
    output logic                      done,
    output logic [tpi_pkg::MAG_W-1:0] frac
);

    tpi_pkg::lane_state_t state_reg, state_next;
    logic [tpi_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [tpi_pkg::NUM_W-1:0] num_reg, num_next;
    logic [tpi_pkg::NUM_W-1:0] den_reg, den_next;
    logic [tpi_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [tpi_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [tpi_pkg::MAG_W-1:0] quo_reg, quo_next;
    logic [6:0]                step_reg, step_next;
    logic                      done_reg, done_next;
    logic [tpi_pkg::NUM_W:0]   shifted;
    logic                      qbit;

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        shifted    = {rem_reg, acc_reg[tpi_pkg::ACC_W-1]};
        qbit       = shifted >= {1'b0, den_reg};
        case (state_reg)
            tpi_pkg::L_IDLE: begin
                if (start) begin
                    mag_next   = mag;
                    num_next   = num;
                    den_next   = den;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = tpi_pkg::L_MUL;
                end
            end
            tpi_pkg::L_MUL: begin
                acc_next = {acc_reg[tpi_pkg::ACC_W-2:0], 1'b0}
                         + (num_reg[tpi_pkg::NUM_W-1] ? tpi_pkg::ACC_W'(mag_reg)
                                                      : tpi_pkg::ACC_W'(0));
                num_next  = {num_reg[tpi_pkg::NUM_W-2:0], 1'b0};
                step_next = step_reg + 7'd1;
                if (step_reg == 7'(tpi_pkg::MUL_STEPS - 1)) begin
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = '0;
                    state_next = tpi_pkg::L_DIV;
                end
            end
            tpi_pkg::L_DIV: begin
                acc_next  = {acc_reg[tpi_pkg::ACC_W-2:0], 1'b0};
                rem_next  = qbit ? tpi_pkg::NUM_W'(shifted - {1'b0, den_reg})
                                 : shifted[tpi_pkg::NUM_W-1:0];
                quo_next  = {quo_reg[tpi_pkg::MAG_W-2:0], qbit};
                step_next = step_reg + 7'd1;
                if (step_reg == 7'(tpi_pkg::DIV_STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = tpi_pkg::L_IDLE;
                end
            end
            default: begin
                state_next = tpi_pkg::L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpi_pkg::L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign frac = quo_reg;

endmodule
